// File: rtl/abprm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abprm_pkg: shared definitions for the audio block peak and RMS meter
// Field widths, queue sizing, square root sizing and the queue status type.
// ----------------------------------------------------------------------------
package abprm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W = 16;
  localparam int FILL_W = 4;
  localparam int HLEN_W = 4;
  localparam int SQ_W = 32;

  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 72;

  localparam int HISTORY_DEPTH_DEFAULT = 10;
  localparam int MAX_BLOCK_DEFAULT = 65536;
  localparam logic [HLEN_W-1:0] HLEN_RESET = 4'd10;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam int RAD_W = 32;
  localparam int ROOT_W = 16;
  localparam int SREM_W = 18;
  localparam int SQ_STEPS = 16;
  localparam int SQ_CNT_W = 4;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } fifo_stat_t;

endpackage
`default_nettype wire

// File: rtl/abprm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abprm_front: sample intake and block accumulation
// Takes one sample per cycle while the queue has room, tracks the block peak
// and the sum of squares of up to MAX_BLOCK samples, and queues the summary.
// ----------------------------------------------------------------------------
module abprm_front #(
  parameter int MAX_BLOCK = abprm_pkg::MAX_BLOCK_DEFAULT,
  parameter int CNT_W = $clog2(MAX_BLOCK + 1),
  parameter int SUM_W = CNT_W + 30
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire  [abprm_pkg::SAMPLE_W-1:0]       s_axis_tdata,
  input  wire                                  s_axis_tlast,
  input  wire  abprm_pkg::fifo_stat_t          fifo_stat,
  output logic                                 push,
  output logic [abprm_pkg::LEVEL_W+SUM_W+CNT_W-1:0] push_data
);

  logic                             st_valid;
  logic                             st_last;
  logic [abprm_pkg::LEVEL_W-1:0]    st_mag;
  logic [abprm_pkg::SQ_W-1:0]       st_sq;
  logic [abprm_pkg::LEVEL_W-1:0]    run_peak;
  logic [SUM_W-1:0]                 sq_sum;
  logic [CNT_W-1:0]                 cnt;

  logic [abprm_pkg::LEVEL_W-1:0]    mag;
  logic [abprm_pkg::SQ_W-1:0]       sq;
  logic [abprm_pkg::QCNT_W-1:0]     pend;
  logic                             accept;
  logic [abprm_pkg::LEVEL_W-1:0]    peak_next;
  logic [SUM_W-1:0]                 sum_next;
  logic [CNT_W-1:0]                 cnt_next;

  assign mag = s_axis_tdata[abprm_pkg::SAMPLE_W-1] ?
               abprm_pkg::LEVEL_W'(-s_axis_tdata) : abprm_pkg::LEVEL_W'(s_axis_tdata);
  assign sq = abprm_pkg::SQ_W'(mag) * abprm_pkg::SQ_W'(mag);

  assign pend = fifo_stat.count + abprm_pkg::QCNT_W'(st_valid & st_last);
  assign s_axis_tready = pend < abprm_pkg::QCNT_W'(abprm_pkg::QUEUE_DEPTH);
  assign accept = s_axis_tvalid & s_axis_tready;

  always_comb begin
    peak_next = (st_mag > run_peak) ? st_mag : run_peak;
    sum_next = sq_sum;
    cnt_next = cnt;
    if (cnt < CNT_W'(MAX_BLOCK)) begin
      sum_next = sq_sum + SUM_W'(st_sq);
      cnt_next = cnt + CNT_W'(1);
    end
  end

  assign push = st_valid & st_last;
  assign push_data = {peak_next, sum_next, cnt_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
      st_last <= 1'b0;
      run_peak <= '0;
      sq_sum <= '0;
      cnt <= '0;
    end else begin
      st_valid <= accept;
      if (accept) begin
        st_last <= s_axis_tlast;
        st_mag <= mag;
        st_sq <= sq;
      end
      if (st_valid) begin
        if (st_last) begin
          run_peak <= '0;
          sq_sum <= '0;
          cnt <= '0;
        end else begin
          run_peak <= peak_next;
          sq_sum <= sum_next;
          cnt <= cnt_next;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/abprm_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abprm_fifo: block summary queue
// A short first-in first-out queue between the intake and the block engine.
// ----------------------------------------------------------------------------
module abprm_fifo #(
  parameter int DATA_W = 80
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          push,
  input  wire  [DATA_W-1:0]            push_data,
  input  wire                          pop,
  output logic [DATA_W-1:0]            head,
  output abprm_pkg::fifo_stat_t        stat
);

  logic [DATA_W-1:0]               entries [abprm_pkg::QUEUE_DEPTH];
  logic [abprm_pkg::QPTR_W-1:0]    wr_ptr;
  logic [abprm_pkg::QPTR_W-1:0]    rd_ptr;
  logic [abprm_pkg::QCNT_W-1:0]    count;

  assign head = entries[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.count = count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + abprm_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + abprm_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + abprm_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - abprm_pkg::QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/abprm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abprm_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, with a done pulse at the end.
// ----------------------------------------------------------------------------
module abprm_div #(
  parameter int N_W = 47,
  parameter int D_W = 17
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  wire  [N_W-1:0]    dividend,
  input  wire  [D_W-1:0]    divisor,
  output logic              done,
  output logic [N_W-1:0]    quotient
);

  localparam int CW = $clog2(N_W + 1);

  logic           busy;
  logic [CW-1:0]  cnt;
  logic [D_W-1:0] rem;
  logic [D_W-1:0] dvs;
  logic [D_W:0]   rem_sh;
  logic           qbit;

  assign rem_sh = {rem, quotient[N_W-1]};
  assign qbit = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= !start && busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(N_W);
        quotient <= dividend;
        dvs <= divisor;
        rem <= '0;
      end else if (busy) begin
        quotient <= {quotient[N_W-2:0], qbit};
        rem <= qbit ? D_W'(rem_sh - {1'b0, dvs}) : D_W'(rem_sh);
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/abprm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abprm_back: block engine
// Per block: mean square by division, integer square root, history update,
// history sums, the two averages, and the registered result stage.
// ----------------------------------------------------------------------------
module abprm_back #(
  parameter int MAX_BLOCK = abprm_pkg::MAX_BLOCK_DEFAULT,
  parameter int HISTORY_DEPTH = abprm_pkg::HISTORY_DEPTH_DEFAULT,
  parameter int CNT_W = $clog2(MAX_BLOCK + 1),
  parameter int SUM_W = CNT_W + 30
) (
  input  wire                                         clk,
  input  wire                                         rst,
  input  wire                                         cfg_we,
  input  wire  [abprm_pkg::HLEN_W-1:0]                cfg_wdata,
  input  wire  abprm_pkg::fifo_stat_t                 fifo_stat,
  input  wire  [abprm_pkg::LEVEL_W+SUM_W+CNT_W-1:0]   head,
  output logic                                        pop,
  output logic                                        m_axis_tvalid,
  input  wire                                         m_axis_tready,
  output logic [abprm_pkg::OUT_TDATA_W-1:0]           m_axis_tdata
);

  localparam int HIDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HCNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int EL_W = (HCNT_W > abprm_pkg::HLEN_W) ? HCNT_W : abprm_pkg::HLEN_W;
  localparam int PS_W = abprm_pkg::LEVEL_W + HCNT_W;
  localparam int N_W = (SUM_W > PS_W) ? SUM_W : PS_W;
  localparam int D_W = (CNT_W > HCNT_W) ? CNT_W : HCNT_W;
  localparam int LW = abprm_pkg::LEVEL_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MS_DIV,
    S_SQRT,
    S_HIST,
    S_SUM_RD,
    S_SUM_ACC,
    S_AVG_P,
    S_AVG_R,
    S_OUT
  } state_t;

  state_t                           state;
  logic [abprm_pkg::HLEN_W-1:0]     hlen;

  logic [LW-1:0]                    peak_mem [HISTORY_DEPTH];
  logic [LW-1:0]                    rms_mem [HISTORY_DEPTH];
  logic [LW-1:0]                    peak_rd;
  logic [LW-1:0]                    rms_rd;

  logic [HIDX_W-1:0]                slot;
  logic [HIDX_W-1:0]                rd_idx;
  logic [HCNT_W-1:0]                hcount;
  logic [HCNT_W-1:0]                used;
  logic [HCNT_W-1:0]                left;

  logic [LW-1:0]                    blk_peak;
  logic [LW-1:0]                    blk_rms;
  logic [LW-1:0]                    peak_mean;
  logic [PS_W-1:0]                  psum;
  logic [PS_W-1:0]                  rsum;

  logic [abprm_pkg::RAD_W-1:0]      rad;
  logic [abprm_pkg::ROOT_W-1:0]     root;
  logic [abprm_pkg::SREM_W-1:0]     srem;
  logic [abprm_pkg::SQ_CNT_W-1:0]   sq_cnt;

  logic                             div_start;
  logic                             div_start_next;
  logic [N_W-1:0]                   div_a;
  logic [D_W-1:0]                   div_b;
  logic                             div_done;
  logic [N_W-1:0]                   div_q;

  logic [abprm_pkg::SREM_W+1:0]     sq_sh;
  logic [abprm_pkg::SREM_W+1:0]     sq_trial;
  logic                             sq_take;
  logic [HCNT_W-1:0]                hcount_next;
  logic [EL_W-1:0]                  hl_ext;
  logic [EL_W-1:0]                  eff_len;
  logic [EL_W-1:0]                  hc_ext;
  logic [HCNT_W-1:0]                used_next;
  logic [LW-1:0]                    head_peak;
  logic [SUM_W-1:0]                 head_sum;
  logic [CNT_W-1:0]                 head_cnt;

  abprm_div #(
    .N_W(N_W),
    .D_W(D_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  assign {head_peak, head_sum, head_cnt} = head;
  assign pop = (state == S_IDLE) && !fifo_stat.empty;

  assign div_start_next = ((state == S_IDLE) && !fifo_stat.empty) ||
                          ((state == S_SUM_ACC) && (left == HCNT_W'(1))) ||
                          ((state == S_AVG_P) && div_done);

  assign sq_sh = {srem, rad[abprm_pkg::RAD_W-1 -: 2]};
  assign sq_trial = (abprm_pkg::SREM_W + 2)'({root, 2'b01});
  assign sq_take = sq_sh >= sq_trial;

  always_comb begin
    hcount_next = (hcount < HCNT_W'(HISTORY_DEPTH)) ? hcount + HCNT_W'(1) : hcount;
    hl_ext = EL_W'(hlen);
    if (hl_ext == '0) begin
      eff_len = EL_W'(1);
    end else if (hl_ext > EL_W'(HISTORY_DEPTH)) begin
      eff_len = EL_W'(HISTORY_DEPTH);
    end else begin
      eff_len = hl_ext;
    end
    hc_ext = EL_W'(hcount_next);
    used_next = HCNT_W'((hc_ext < eff_len) ? hc_ext : eff_len);
  end

  always_ff @(posedge clk) begin
    if (state == S_HIST) begin
      peak_mem[slot] <= blk_peak;
      rms_mem[slot] <= blk_rms;
    end
    peak_rd <= peak_mem[rd_idx];
    rms_rd <= rms_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hlen <= abprm_pkg::HLEN_RESET;
    end else if (cfg_we) begin
      hlen <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot <= '0;
      rd_idx <= '0;
      hcount <= '0;
      div_start <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      div_start <= div_start_next;
      if (m_axis_tvalid && m_axis_tready && (state != S_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!fifo_stat.empty) begin
            blk_peak <= head_peak;
            div_a <= N_W'(head_sum);
            div_b <= D_W'(head_cnt);
            state <= S_MS_DIV;
          end
        end
        S_MS_DIV: begin
          if (div_done) begin
            rad <= abprm_pkg::RAD_W'(div_q);
            root <= '0;
            srem <= '0;
            sq_cnt <= abprm_pkg::SQ_CNT_W'(abprm_pkg::SQ_STEPS - 1);
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          rad <= {rad[abprm_pkg::RAD_W-3:0], 2'b00};
          srem <= sq_take ? abprm_pkg::SREM_W'(sq_sh - sq_trial) : abprm_pkg::SREM_W'(sq_sh);
          root <= {root[abprm_pkg::ROOT_W-2:0], sq_take};
          sq_cnt <= sq_cnt - abprm_pkg::SQ_CNT_W'(1);
          if (sq_cnt == '0) begin
            blk_rms <= LW'({root[abprm_pkg::ROOT_W-2:0], sq_take});
            state <= S_HIST;
          end
        end
        S_HIST: begin
          slot <= (slot == HIDX_W'(HISTORY_DEPTH - 1)) ? '0 : slot + HIDX_W'(1);
          rd_idx <= slot;
          hcount <= hcount_next;
          used <= used_next;
          left <= used_next;
          psum <= '0;
          rsum <= '0;
          state <= S_SUM_RD;
        end
        S_SUM_RD: begin
          state <= S_SUM_ACC;
        end
        S_SUM_ACC: begin
          psum <= psum + PS_W'(peak_rd);
          rsum <= rsum + PS_W'(rms_rd);
          rd_idx <= (rd_idx == '0) ? HIDX_W'(HISTORY_DEPTH - 1) : rd_idx - HIDX_W'(1);
          left <= left - HCNT_W'(1);
          if (left == HCNT_W'(1)) begin
            div_a <= N_W'(psum + PS_W'(peak_rd));
            div_b <= D_W'(used);
            state <= S_AVG_P;
          end else begin
            state <= S_SUM_RD;
          end
        end
        S_AVG_P: begin
          if (div_done) begin
            peak_mean <= LW'(div_q);
            div_a <= N_W'(rsum);
            div_b <= D_W'(used);
            state <= S_AVG_R;
          end
        end
        S_AVG_R: begin
          if (div_done) begin
            div_a <= div_q;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= abprm_pkg::OUT_TDATA_W'({abprm_pkg::FILL_W'(used),
                                                     LW'(div_a), peak_mean,
                                                     blk_rms, blk_peak});
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/audio_block_peak_rms_meter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// audio_block_peak_rms_meter: block peak and RMS level meter
// Samples stream in on s_axis, one transfer per sample, with tlast on the
// final sample of each block. Each finished block yields one transfer on
// m_axis carrying the block peak, the block RMS (integer square root of the
// truncated mean square), the truncated means of the most recent peaks and
// RMS values, and the number of blocks averaged.
// The intake takes one sample per cycle. The block engine takes one block
// at a time; its time per block grows with N, the divider width (47 bits
// with the default block limit), and with F, the number of blocks
// averaged, and is set mostly by the shared iterative divider. A queue of
// four block summaries sits between the two, so short blocks are absorbed
// until it fills, after which s_axis_tready drops. The result register
// holds each result while m_axis_tready is low. Reset clears the running
// block, the history and the queue, and sets history_length to 10.
// ----------------------------------------------------------------------------
module audio_block_peak_rms_meter #(
  parameter int HISTORY_DEPTH = abprm_pkg::HISTORY_DEPTH_DEFAULT,
  parameter int MAX_BLOCK = abprm_pkg::MAX_BLOCK_DEFAULT
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_we,
  input  wire  [abprm_pkg::HLEN_W-1:0]          cfg_wdata,      // history_length
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire  [abprm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // sample
  input  wire                                   s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  // block_peak, block_rms, average_peak, average_rms, history_fill, zero pad
  output logic [abprm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W = CNT_W + 30;
  localparam int Q_W = abprm_pkg::LEVEL_W + SUM_W + CNT_W;

  abprm_pkg::fifo_stat_t  fifo_stat;
  logic                   fifo_push;
  logic [Q_W-1:0]         fifo_wdata;
  logic                   fifo_pop;
  logic [Q_W-1:0]         fifo_head;

  abprm_front #(
    .MAX_BLOCK(MAX_BLOCK),
    .CNT_W(CNT_W),
    .SUM_W(SUM_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .fifo_stat     (fifo_stat),
    .push          (fifo_push),
    .push_data     (fifo_wdata)
  );

  abprm_fifo #(
    .DATA_W(Q_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fifo_push),
    .push_data (fifo_wdata),
    .pop       (fifo_pop),
    .head      (fifo_head),
    .stat      (fifo_stat)
  );

  abprm_back #(
    .MAX_BLOCK(MAX_BLOCK),
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .CNT_W(CNT_W),
    .SUM_W(SUM_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fifo_stat     (fifo_stat),
    .head          (fifo_head),
    .pop           (fifo_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // The queue is never full while the intake can still take a sample.
  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    fifo_stat.count == abprm_pkg::QCNT_W'(abprm_pkg::QUEUE_DEPTH) |-> !s_axis_tready)
    else $error("input ready while block queue is full");

  // A block summary is never pushed into a full queue.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    fifo_push |-> fifo_stat.count != abprm_pkg::QCNT_W'(abprm_pkg::QUEUE_DEPTH))
    else $error("block summary pushed into full queue");

  // The RMS of a block never exceeds its peak.
  a_rms_le_peak: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[31:16] <= m_axis_tdata[15:0])
    else $error("block RMS above block peak");

endmodule
`default_nettype wire
